@@ rtl/drfp_pkg.sv @@
// shared types and constants for the display return frame parser
`default_nettype none

package drfp_pkg;

	localparam int FRAME_DEPTH = 64;
	localparam int TEXT_CAP    = 32;

	localparam int IDX_W     = $clog2(FRAME_DEPTH);
	localparam int FILL_W    = $clog2(FRAME_DEPTH + 1);
	localparam int TN_W      = $clog2(TEXT_CAP);
	localparam int CNT_W     = (FILL_W > TN_W) ? FILL_W : TN_W;
	localparam int RAM_AW    = IDX_W + 1;
	localparam int RAM_DEPTH = 2 * (1 << IDX_W);
	localparam int Q_DEPTH   = 2;

	localparam logic [7:0] BYTE_TERM  = 8'hFF;
	localparam logic [7:0] HDR_TOUCH  = 8'h65;
	localparam logic [7:0] HDR_PAGE   = 8'h66;
	localparam logic [7:0] HDR_NUMBER = 8'h71;
	localparam logic [7:0] HDR_STRING = 8'h70;

	localparam logic [2:0] KIND_PRESS   = 3'd0;
	localparam logic [2:0] KIND_RELEASE = 3'd1;
	localparam logic [2:0] KIND_PAGE    = 3'd2;
	localparam logic [2:0] KIND_NUMBER  = 3'd3;
	localparam logic [2:0] KIND_STRING  = 3'd4;
	localparam logic [2:0] KIND_ERROR   = 3'd5;

	// one decoded frame waiting for the back end
	typedef struct packed {
		logic [2:0]      kind;
		logic [7:0]      header;
		logic [7:0]      page;
		logic [7:0]      component;
		logic [31:0]     number;
		logic [TN_W-1:0] text_n;
		logic            bank;
	} desc_t;

	// back end hands a frame buffer back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  header;
		logic [7:0]  page;
		logic [7:0]  component;
		logic [31:0] number;
		logic [7:0]  text_char;
		logic        text_valid;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/drfp_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module drfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/drfp_front.sv @@
// front end: byte intake, frame buffering, terminator detection and header decode
`default_nettype none

module drfp_front import drfp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [7:0]        rx_byte,
	output logic                   full,
	output logic                   ram_we,
	output logic [RAM_AW-1:0]      ram_waddr,
	output logic [7:0]             ram_wdata,
	output logic                   q_push,
	output desc_t                  q_desc,
	input  wire logic              q_full,
	input  wire release_t          rel
);

	logic [FILL_W-1:0] fill_q;
	logic [1:0]        ff_run_q;
	logic              bank_q;
	logic [1:0]        busy_q;
	logic [7:0]        fld_q [5];

	logic              acc;
	logic              store;
	logic [FILL_W-1:0] fill_new;
	logic              term;
	logic [FILL_W-1:0] len;
	logic              emit;
	logic [CNT_W-1:0]  len_m1;
	logic [CNT_W-1:0]  n_sel;

	assign full  = q_full || busy_q[bank_q];
	assign acc   = push && !full;
	assign store = fill_q < FILL_W'(FRAME_DEPTH);
	assign fill_new = store ? fill_q + FILL_W'(1) : fill_q;
	assign term  = acc && (rx_byte == BYTE_TERM) && (ff_run_q == 2'd2);
	assign len   = fill_new - FILL_W'(3);

	assign ram_we    = acc && store;
	assign ram_waddr = {bank_q, IDX_W'(fill_q)};
	assign ram_wdata = rx_byte;

	assign len_m1 = CNT_W'(len) - CNT_W'(1);
	assign n_sel  = (len_m1 > CNT_W'(TEXT_CAP - 1)) ? CNT_W'(TEXT_CAP - 1) : len_m1;

	always_comb begin
		emit           = 1'b0;
		q_desc         = '0;
		q_desc.header  = fld_q[0];
		q_desc.bank    = bank_q;
		if (len != '0) begin
			unique case (fld_q[0])
				HDR_TOUCH: begin
					emit             = len >= FILL_W'(4);
					q_desc.kind      = (fld_q[3] != 8'd0) ? KIND_PRESS : KIND_RELEASE;
					q_desc.page      = fld_q[1];
					q_desc.component = fld_q[2];
				end
				HDR_PAGE: begin
					emit        = len >= FILL_W'(2);
					q_desc.kind = KIND_PAGE;
					q_desc.page = fld_q[1];
				end
				HDR_NUMBER: begin
					emit          = len >= FILL_W'(5);
					q_desc.kind   = KIND_NUMBER;
					q_desc.number = {fld_q[4], fld_q[3], fld_q[2], fld_q[1]};
				end
				HDR_STRING: begin
					emit          = 1'b1;
					q_desc.kind   = KIND_STRING;
					q_desc.text_n = TN_W'(n_sel);
				end
				default: begin
					emit        = 1'b1;
					q_desc.kind = KIND_ERROR;
				end
			endcase
		end
	end

	assign q_push = term && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ff_run_q <= '0;
			bank_q   <= 1'b0;
			busy_q   <= '0;
		end else begin
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (acc) begin
				if (term) begin
					fill_q   <= '0;
					ff_run_q <= '0;
					bank_q   <= !bank_q;
					// string readout keeps this buffer until its last byte is out
					if (q_push && q_desc.kind == KIND_STRING && q_desc.text_n != '0) begin
						busy_q[bank_q] <= 1'b1;
					end
				end else begin
					fill_q   <= fill_new;
					ff_run_q <= (rx_byte == BYTE_TERM) ? ff_run_q + 2'd1 : 2'd0;
				end
			end
		end
	end

	// header and the first payload bytes are kept at hand for the decode
	always_ff @(posedge clk) begin
		if (acc && store) begin
			for (int k = 0; k < 5; k++) begin
				if (fill_q == FILL_W'(k)) begin
					fld_q[k] <= rx_byte;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/drfp_queue.sv @@
// short descriptor queue between front and back end
`default_nettype none

module drfp_queue import drfp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t din,
	output logic       full,
	input  wire logic  pop,
	output desc_t      dout,
	output logic       empty
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_QW = $clog2(Q_DEPTH + 1);

	desc_t             ent_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = cnt_q == CNT_QW'(Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign dout    = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

@@ rtl/drfp_back.sv @@
// back end: turns descriptors into results, streams string bytes from the frame ram
`default_nettype none

module drfp_back import drfp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	input  wire desc_t        q_desc,
	output logic              q_pop,
	output logic              ram_re,
	output logic [RAM_AW-1:0] ram_raddr,
	input  wire logic [7:0]   ram_rdata,
	output release_t          rel,
	output logic              empty,
	input  wire logic         pop,
	output result_t           res
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_TEXT = 1'b1;

	logic            state_q;
	logic            state_d;
	logic [TN_W-1:0] idx_q;
	logic [TN_W-1:0] idx_d;
	logic            out_v_q;
	result_t         res_q;
	result_t         res_d;
	logic            load;
	logic            out_free;

	assign out_free = !out_v_q || pop;
	assign empty    = !out_v_q;
	assign res      = res_q;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		q_pop     = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = {q_desc.bank, IDX_W'(idx_q)};
		load      = 1'b0;
		rel       = '0;
		res_d           = '0;
		res_d.kind      = q_desc.kind;
		res_d.header    = q_desc.header;
		res_d.page      = q_desc.page;
		res_d.component = q_desc.component;
		res_d.number    = q_desc.number;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_desc.text_n == '0) begin
						if (out_free) begin
							load       = 1'b1;
							res_d.last = 1'b1;
							q_pop      = 1'b1;
						end
					end else begin
						// text starts right after the header byte
						ram_re    = 1'b1;
						ram_raddr = {q_desc.bank, IDX_W'(1)};
						idx_d     = TN_W'(1);
						state_d   = ST_TEXT;
					end
				end
			end
			ST_TEXT: begin
				if (out_free) begin
					load             = 1'b1;
					res_d.text_char  = ram_rdata;
					res_d.text_valid = 1'b1;
					res_d.last       = idx_q == q_desc.text_n;
					if (idx_q == q_desc.text_n) begin
						q_pop     = 1'b1;
						rel.valid = 1'b1;
						rel.bank  = q_desc.bank;
						state_d   = ST_IDLE;
					end else begin
						idx_d     = idx_q + TN_W'(1);
						ram_re    = 1'b1;
						ram_raddr = {q_desc.bank, IDX_W'(idx_q + TN_W'(1))};
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/display_return_frame_parser.sv @@
// top level of the display return frame parser
`default_nettype none

// Serial return frames from a touch display come in one byte per transaction; a run of three
// 0xFF bytes ends a frame and its events appear on the result side as queue entries. The front
// end takes one byte per clock unless full and stores it in one of two frame buffers in the
// frame ram (two banks of FRAME_DEPTH bytes, no clearing pass after reset). Touch, page and
// number frames of full length and error frames give one result; a string frame gives one
// result per text byte (at most TEXT_CAP - 1, one if empty), read from the ram at one byte
// per clock while results are popped, once the first read is done. full rises while the
// two-entry event queue is full or the next frame's buffer is still being read out as text.
module display_return_frame_parser import drfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       event_kind,
	output logic [7:0]       header,
	output logic [7:0]       page,
	output logic [7:0]       component,
	output logic [31:0]      number,
	output logic [7:0]       text_char,
	output logic             text_valid,
	output logic             last
);

	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	desc_t             q_din;
	desc_t             q_dout;
	release_t          rel;
	result_t           res;

	drfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rx_byte   (rx_byte),
		.full      (full),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.q_push    (q_push),
		.q_desc    (q_din),
		.q_full    (q_full),
		.rel       (rel)
	);

	drfp_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	drfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	drfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_desc    (q_dout),
		.q_pop     (q_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rel       (rel),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign event_kind = res.kind;
	assign header     = res.header;
	assign page       = res.page;
	assign component  = res.component;
	assign number     = res.number;
	assign text_char  = res.text_char;
	assign text_valid = res.text_valid;
	assign last       = res.last;

	// a decoded frame is never offered to a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("descriptor pushed into full queue");

	// a buffer is handed back only as its string descriptor retires
	a_release_with_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> (q_pop && !q_empty))
		else $error("buffer released without retiring a descriptor");

	// the back end never consumes an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty descriptor queue");

	// ram is never read and written at the same address in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("frame ram read of the buffer being filled");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench for the display return frame parser: byte stimulus, frame predictor, result checks
`timescale 1ns / 1ps

module tb import drfp_pkg::*;;

	// frame predictor and store of expected events
	class frame_scoreboard;
		logic [7:0] frame_buf [FRAME_DEPTH];
		int         fill;
		int         ff_count;
		result_t    expected_q [$];
		int         errors;
		int         results_seen;
		int         frames_ended;
		int         overflow_frames;
		int         kind_seen [6];

		function new();
			fill            = 0;
			ff_count        = 0;
			errors          = 0;
			results_seen    = 0;
			frames_ended    = 0;
			overflow_frames = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function void add_result(logic [2:0] kind, logic [7:0] hdr, logic [7:0] pg,
				logic [7:0] comp, logic [31:0] num, logic [7:0] ch, logic valid,
				logic fin);
			result_t r;
			r.kind       = kind;
			r.header     = hdr;
			r.page       = pg;
			r.component  = comp;
			r.number     = num;
			r.text_char  = ch;
			r.text_valid = valid;
			r.last       = fin;
			expected_q.push_back(r);
		endfunction

		function void decode_frame(int len);
			logic [7:0] hdr;
			int         n;
			if (len == 0)
				return;
			hdr = frame_buf[0];
			case (hdr)
				HDR_TOUCH: begin
					if (len >= 4)
						add_result((frame_buf[3] != 8'd0) ? KIND_PRESS : KIND_RELEASE, hdr,
							frame_buf[1], frame_buf[2], 32'd0, 8'd0, 1'b0, 1'b1);
				end
				HDR_PAGE: begin
					if (len >= 2)
						add_result(KIND_PAGE, hdr, frame_buf[1], 8'd0, 32'd0, 8'd0, 1'b0, 1'b1);
				end
				HDR_NUMBER: begin
					if (len >= 5)
						add_result(KIND_NUMBER, hdr, 8'd0, 8'd0,
							{frame_buf[4], frame_buf[3], frame_buf[2], frame_buf[1]},
							8'd0, 1'b0, 1'b1);
				end
				HDR_STRING: begin
					n = len - 1;
					if (n > TEXT_CAP - 1)
						n = TEXT_CAP - 1;
					if (n == 0)
						add_result(KIND_STRING, hdr, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 1'b1);
					for (int i = 0; i < n; i++)
						add_result(KIND_STRING, hdr, 8'd0, 8'd0, 32'd0, frame_buf[i + 1], 1'b1,
							(i + 1 == n));
				end
				default: begin
					add_result(KIND_ERROR, hdr, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 1'b1);
				end
			endcase
		endfunction

		// one accepted byte transaction
		function void note_byte(logic [7:0] d);
			if (fill < FRAME_DEPTH) begin
				frame_buf[fill] = d;
				fill++;
			end
			if (d == BYTE_TERM)
				ff_count++;
			else
				ff_count = 0;
			if (ff_count >= 3) begin
				frames_ended++;
				if (fill == FRAME_DEPTH)
					overflow_frames++;
				if (fill >= 3)
					decode_frame(fill - 3);
				fill     = 0;
				ff_count = 0;
			end
		endfunction

		function string show(result_t r);
			return $sformatf("kind %0d hdr %h page %h comp %h num %h char %h valid %b last %b",
				r.kind, r.header, r.page, r.component, r.number, r.text_char, r.text_valid,
				r.last);
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (got.kind < 6)
				kind_seen[got.kind]++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result at %0t: %s", $time, show(got));
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.header !== want.header ||
					got.page !== want.page || got.component !== want.component ||
					got.number !== want.number || got.text_char !== want.text_char ||
					got.text_valid !== want.text_valid || got.last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch at %0t", $time);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  event_kind;
	logic [7:0]  header;
	logic [7:0]  page;
	logic [7:0]  component;
	logic [31:0] number;
	logic [7:0]  text_char;
	logic        text_valid;
	logic        last;

	frame_scoreboard sb = new();
	int              burst_left = 0;
	int              bytes_sent = 0;
	int              rx_cycle   = 0;

	display_return_frame_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.event_kind (event_kind),
		.header     (header),
		.page       (page),
		.component  (component),
		.number     (number),
		.text_char  (text_char),
		.text_valid (text_valid),
		.last       (last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// monitor both sides and drive the receiver stall pattern
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (push && !full)
				sb.note_byte(rx_byte);
			if (pop && !empty) begin
				got.kind       = event_kind;
				got.header     = header;
				got.page       = page;
				got.component  = component;
				got.number     = number;
				got.text_char  = text_char;
				got.text_valid = text_valid;
				got.last       = last;
				sb.check_result(got);
			end
			rx_cycle++;
			case ((rx_cycle / 97) % 4)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 4) == 0);
				default: pop <= ((rx_cycle % 16) < 10);
			endcase
		end
	end

	task automatic send_data(input logic [7:0] d);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		push    <= 1'b1;
		rx_byte <= d;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_term();
		repeat (3) send_data(BYTE_TERM);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		burst_left = 0;
	endtask

	// body byte: mostly below 0xFF, now and then a terminator byte
	function automatic logic [7:0] body_byte();
		return ($urandom_range(0, 15) == 0) ? BYTE_TERM : 8'($urandom_range(0, 254));
	endfunction

	task automatic random_frame(input bit force_overflow);
		int         sel;
		int         n;
		logic [7:0] hdr;
		sel = force_overflow ? 60 : $urandom_range(0, 99);
		if (sel < 20) begin
			send_data(HDR_TOUCH);
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3 + $urandom_range(0, 2);
			for (int i = 0; i < n; i++)
				send_data((i == 2 && $urandom_range(0, 1)) ? 8'd0 : body_byte());
			send_term();
		end else if (sel < 35) begin
			send_data(HDR_PAGE);
			n = ($urandom_range(0, 5) == 0) ? 0 : 1 + $urandom_range(0, 1);
			repeat (n) send_data(body_byte());
			send_term();
		end else if (sel < 50) begin
			send_data(HDR_NUMBER);
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 4;
			repeat (n) send_data(8'($urandom_range(0, 254)));
			send_term();
		end else if (sel < 75) begin
			send_data(HDR_STRING);
			if (force_overflow)
				n = $urandom_range(62, 70);
			else if ($urandom_range(0, 7) == 0)
				n = $urandom_range(25, 40);
			else
				n = $urandom_range(0, 8);
			repeat (n) send_data(($urandom_range(0, 7) == 0) ? 8'd0 : body_byte());
			send_term();
		end else if (sel < 85) begin
			// header outside the known set
			do
				hdr = 8'($urandom_range(0, 255));
			while (hdr == HDR_TOUCH || hdr == HDR_PAGE || hdr == HDR_NUMBER ||
				hdr == HDR_STRING);
			send_data(hdr);
			repeat ($urandom_range(0, 3)) send_data(body_byte());
			send_term();
		end else if (sel < 92) begin
			repeat ($urandom_range(1, 6)) send_data(8'($urandom_range(0, 255)));
		end else begin
			// broken terminator followed by a fresh one
			send_data(BYTE_TERM);
			send_data(BYTE_TERM);
			send_data(8'($urandom_range(0, 254)));
			send_term();
		end
	endtask

	initial begin
		arst_n  <= 1'b0;
		push    <= 1'b0;
		pop     <= 1'b0;
		rx_byte <= 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// press with extreme page and component, release, short touch
		send_data(HDR_TOUCH); send_data(8'h00); send_data(8'hFE); send_data(8'h01); send_term();
		send_data(HDR_TOUCH); send_data(8'hFE); send_data(8'h00); send_data(8'h00); send_term();
		send_data(HDR_TOUCH); send_data(8'h01); send_term();
		// page change, short page frame
		send_data(HDR_PAGE); send_data(8'hAB); send_term();
		send_data(HDR_PAGE); send_term();
		// number with top and bottom bits set, short number frame
		send_data(HDR_NUMBER); send_data(8'h01); send_data(8'hFE); send_data(8'h00);
		send_data(8'h80); send_term();
		send_data(HDR_NUMBER); send_data(8'h01); send_data(8'h02); send_term();
		// empty string, string with a zero byte
		send_data(HDR_STRING); send_term();
		send_data(HDR_STRING); send_data(8'h00); send_data(8'h41); send_term();
		// unknown header, empty frame
		send_data(8'h00); send_term();
		send_term();
		wait_drained();

		for (int f = 0; bytes_sent < 310; f++) begin
			random_frame(f == 5);
			if (bytes_sent >= 150 && bytes_sent < 170)
				wait_drained();
		end

		wait_drained();
		repeat (40) @(posedge clk);
		sb.errors += sb.pending();
		$display("ran %0d frames (%0d filling the store), %0d results checked",
			sb.frames_ended, sb.overflow_frames, sb.results_seen);
		$display("touch %0d/%0d, page %0d, number %0d, string %0d, error %0d, failures %0d",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
			sb.kind_seen[4], sb.kind_seen[5], sb.errors);
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout");
		$display("tb NOT OK");
		$finish;
	end

endmodule

@@ display_return_frame_parser.f @@
rtl/drfp_pkg.sv
rtl/drfp_ram.sv
rtl/drfp_front.sv
rtl/drfp_queue.sv
rtl/drfp_back.sv
rtl/display_return_frame_parser.sv
tb/tb.sv
